FILE: hw/rtl/spq_pkg.sv
// shared types, codes and defaults for the stable priority queue
package spq_pkg;

  // default sizing
  localparam int SPQ_DEPTH     = 16;
  localparam int SPQ_TAG_BITS  = 32;
  localparam int SPQ_PRIO_BITS = 16;

  // register port
  localparam int SPQ_CFG_ADDR_W = 3;
  localparam int SPQ_CFG_DATA_W = 32;
  localparam logic [SPQ_CFG_ADDR_W-1:0] REG_QUEUE_MODE = 3'd0;

  // command codes
  typedef logic [1:0] spq_cmd_t;
  localparam spq_cmd_t CMD_PUSH   = 2'd0;
  localparam spq_cmd_t CMD_POP    = 2'd1;
  localparam spq_cmd_t CMD_REMOVE = 2'd2;
  localparam spq_cmd_t CMD_PROBE  = 2'd3;

  // status codes
  typedef logic [1:0] spq_status_t;
  localparam spq_status_t ST_OK   = 2'd0;
  localparam spq_status_t ST_MISS = 2'd1;
  localparam spq_status_t ST_MODE = 2'd2;
  localparam spq_status_t ST_FULL = 2'd3;

  // result flags handed from the engine to the output stage
  typedef struct packed {
    spq_status_t status;
    logic        found;
    logic        empty;
  } spq_flags_t;

endpackage

FILE: hw/rtl/spq_engine.sv
// entry store and sequencer: scan, shift, insert and drop over one memory port pair
module spq_engine #(
  parameter int DEPTH     = spq_pkg::SPQ_DEPTH,
  parameter int TAG_BITS  = spq_pkg::SPQ_TAG_BITS,
  parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  spq_pkg::spq_cmd_t            cmd,
  input  logic [TAG_BITS-1:0]          tag,
  input  logic [PRIO_BITS-1:0]         prio,
  input  logic                         mode,
  input  logic                         res_ready,
  output logic                         busy,
  output logic                         done,
  output spq_pkg::spq_flags_t          flags,
  output logic [TAG_BITS-1:0]          res_tag,
  output logic [PRIO_BITS-1:0]         res_prio,
  output logic [TAG_BITS-1:0]          res_head,
  output logic [$clog2(DEPTH+1)-1:0]   res_count
);
  import spq_pkg::*;

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ENTRY_W = TAG_BITS + PRIO_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] S_SCAN_RD  = 4'd1;
  localparam logic [ST_W-1:0] S_SCAN_CHK = 4'd2;
  localparam logic [ST_W-1:0] S_UP_RD    = 4'd3;
  localparam logic [ST_W-1:0] S_UP_WR    = 4'd4;
  localparam logic [ST_W-1:0] S_INS      = 4'd5;
  localparam logic [ST_W-1:0] S_POP_RD   = 4'd6;
  localparam logic [ST_W-1:0] S_POP_CAP  = 4'd7;
  localparam logic [ST_W-1:0] S_DN_RD    = 4'd8;
  localparam logic [ST_W-1:0] S_DN_WR    = 4'd9;
  localparam logic [ST_W-1:0] S_HEAD_RD  = 4'd10;
  localparam logic [ST_W-1:0] S_HEAD_CAP = 4'd11;
  localparam logic [ST_W-1:0] S_FIN      = 4'd12;

  logic [ST_W-1:0]      state_r, state_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  spq_cmd_t             cmd_r, cmd_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  spq_status_t          status_r, status_nxt;
  logic                 found_r, found_nxt;
  logic [TAG_BITS-1:0]  otag_r, otag_nxt;
  logic [PRIO_BITS-1:0] oprio_r, oprio_nxt;
  logic [TAG_BITS-1:0]  head_r, head_nxt;

  logic [ENTRY_W-1:0]   mem_r [DEPTH];
  logic [ENTRY_W-1:0]   rdata_r;
  logic                 re, we;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [ENTRY_W-1:0]   wdata;

  logic [TAG_BITS-1:0]  rd_tag;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 hit;
  logic [CNT_W-1:0]     idx_inc, idx_dec;

  assign rd_tag  = rdata_r[TAG_BITS-1:0];
  assign rd_prio = rdata_r[ENTRY_W-1 -: PRIO_BITS];
  assign idx_inc = idx_r + 1'b1;
  assign idx_dec = idx_r - 1'b1;

  // the one compare unit, reused for every entry of a scan
  always_comb begin
    unique case (cmd_r)
      CMD_PUSH:   hit = rd_prio > prio_r;
      CMD_REMOVE: hit = (rd_prio == prio_r) && (rd_tag == tag_r);
      CMD_PROBE:  hit = rd_prio == prio_r;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    tag_nxt    = tag_r;
    prio_nxt   = prio_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    otag_nxt   = otag_r;
    oprio_nxt  = oprio_r;
    head_nxt   = head_r;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    done       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          tag_nxt    = tag;
          prio_nxt   = prio;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          otag_nxt   = '0;
          oprio_nxt  = '0;
          idx_nxt    = '0;
          unique case (cmd)
            CMD_PUSH: begin
              if (occ_r == FULL_CNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_HEAD_RD;
              end else if (mode) begin
                state_nxt = S_SCAN_RD;
              end else begin
                pos_nxt   = occ_r;
                idx_nxt   = occ_r;
                state_nxt = S_UP_RD;
              end
            end
            CMD_POP: begin
              if (occ_r == '0) begin
                status_nxt = ST_MISS;
                state_nxt  = S_HEAD_RD;
              end else begin
                state_nxt = S_POP_RD;
              end
            end
            CMD_REMOVE, CMD_PROBE: begin
              if (!mode) begin
                status_nxt = ST_MODE;
                state_nxt  = S_HEAD_RD;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx_r == occ_r) begin
          // ran off the end without a hit
          if (cmd_r == CMD_PUSH) begin
            pos_nxt   = occ_r;
            idx_nxt   = occ_r;
            state_nxt = S_UP_RD;
          end else begin
            status_nxt = ST_MISS;
            state_nxt  = S_HEAD_RD;
          end
        end else begin
          re        = 1'b1;
          raddr     = idx_r[ADDR_W-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (hit) begin
          priority case (cmd_r)
            CMD_PUSH: begin
              pos_nxt   = idx_r;
              idx_nxt   = occ_r;
              state_nxt = S_UP_RD;
            end
            CMD_REMOVE: begin
              otag_nxt  = rd_tag;
              oprio_nxt = rd_prio;
              state_nxt = S_DN_RD;
            end
            default: begin
              found_nxt = 1'b1;
              state_nxt = S_HEAD_RD;
            end
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_UP_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          re        = 1'b1;
          raddr     = idx_dec[ADDR_W-1:0];
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        we        = 1'b1;
        waddr     = idx_r[ADDR_W-1:0];
        wdata     = rdata_r;
        idx_nxt   = idx_dec;
        state_nxt = S_UP_RD;
      end
      S_INS: begin
        we        = 1'b1;
        waddr     = pos_r[ADDR_W-1:0];
        wdata     = {prio_r, tag_r};
        occ_nxt   = occ_r + 1'b1;
        state_nxt = S_HEAD_RD;
      end
      S_POP_RD: begin
        re        = 1'b1;
        raddr     = '0;
        state_nxt = S_POP_CAP;
      end
      S_POP_CAP: begin
        otag_nxt  = rd_tag;
        oprio_nxt = mode ? rd_prio : '0;
        idx_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (idx_inc >= occ_r) begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_HEAD_RD;
        end else begin
          re        = 1'b1;
          raddr     = idx_inc[ADDR_W-1:0];
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        we        = 1'b1;
        waddr     = idx_r[ADDR_W-1:0];
        wdata     = rdata_r;
        idx_nxt   = idx_inc;
        state_nxt = S_DN_RD;
      end
      S_HEAD_RD: begin
        if (occ_r == '0) begin
          head_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          re        = 1'b1;
          raddr     = '0;
          state_nxt = S_HEAD_CAP;
        end
      end
      S_HEAD_CAP: begin
        head_nxt  = rd_tag;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    cmd_r    <= cmd_nxt;
    tag_r    <= tag_nxt;
    prio_r   <= prio_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    otag_r   <= otag_nxt;
    oprio_r  <= oprio_nxt;
    head_r   <= head_nxt;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign busy         = state_r != S_IDLE;
  assign flags.status = status_r;
  assign flags.found  = found_r;
  assign flags.empty  = occ_r == '0;
  assign res_tag      = otag_r;
  assign res_prio     = oprio_r;
  assign res_head     = head_r;
  assign res_count    = occ_r;

endmodule

FILE: hw/rtl/stable_priority_queue.sv
// stable priority queue top level: register port, handshakes and result register
// run length: an item's result waits on a scan, a shift or both over the stored entries;
//   the longest run is an ordered push ahead of DEPTH-1 entries
// throughput: one item at a time, the next is taken the cycle after the result moves to the
//   output register, paced by the one memory port pair that scan and shift share
// reset: rst_n (synchronous, active low) empties the queue and selects plain mode, memory kept
module stable_priority_queue #(
  parameter int DEPTH     = spq_pkg::SPQ_DEPTH,
  parameter int TAG_BITS  = spq_pkg::SPQ_TAG_BITS,
  parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [spq_pkg::SPQ_CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [spq_pkg::SPQ_CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [spq_pkg::SPQ_CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                cfg_pready,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spq_pkg::spq_cmd_t                   in_cmd,
  input  logic [TAG_BITS-1:0]                 in_item_tag,
  input  logic [PRIO_BITS-1:0]                in_priority_req,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output spq_pkg::spq_status_t                out_status,
  output logic [TAG_BITS-1:0]                 out_out_tag,
  output logic [PRIO_BITS-1:0]                out_out_priority,
  output logic                                out_probe_found,
  output logic [TAG_BITS-1:0]                 out_head_tag,
  output logic                                out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0]          out_entry_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // queue_mode register: 0 plain fifo, 1 ascending priority
  logic mode_r, mode_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && (cfg_paddr == REG_QUEUE_MODE)) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_QUEUE_MODE) begin
      cfg_prdata = {{(SPQ_CFG_DATA_W-1){1'b0}}, mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // engine: takes one item, runs until its result is handed over
  logic                 eng_start;
  logic                 eng_busy;
  logic                 eng_done;
  logic                 res_ready;
  spq_flags_t           eng_flags;
  logic [TAG_BITS-1:0]  eng_tag;
  logic [PRIO_BITS-1:0] eng_prio;
  logic [TAG_BITS-1:0]  eng_head;
  logic [CNT_W-1:0]     eng_count;

  // a new item may enter while the previous result still waits downstream
  assign in_stall  = eng_busy;
  assign eng_start = in_valid && !in_stall;

  spq_engine #(
    .DEPTH     (DEPTH),
    .TAG_BITS  (TAG_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (eng_start),
    .cmd       (in_cmd),
    .tag       (in_item_tag),
    .prio      (in_priority_req),
    .mode      (mode_r),
    .res_ready (res_ready),
    .busy      (eng_busy),
    .done      (eng_done),
    .flags     (eng_flags),
    .res_tag   (eng_tag),
    .res_prio  (eng_prio),
    .res_head  (eng_head),
    .res_count (eng_count)
  );

  // result register: the engine finishes only when this slot is free or draining
  logic                 out_valid_r, out_valid_nxt;
  spq_flags_t           out_flags_r;
  logic [TAG_BITS-1:0]  out_tag_r;
  logic [PRIO_BITS-1:0] out_prio_r;
  logic [TAG_BITS-1:0]  out_head_r;
  logic [CNT_W-1:0]     out_count_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_flags_r <= eng_flags;
      out_tag_r   <= eng_tag;
      out_prio_r  <= eng_prio;
      out_head_r  <= eng_head;
      out_count_r <= eng_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_flags_r.status;
  assign out_out_tag      = out_tag_r;
  assign out_out_priority = out_prio_r;
  assign out_probe_found  = out_flags_r.found;
  assign out_head_tag     = out_head_r;
  assign out_is_empty     = out_flags_r.empty;
  assign out_entry_count  = out_count_r;

  // an accepted item keeps the engine busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_start |=> in_stall)
    else $error("engine not busy after item accepted");

  // the engine never finishes into an occupied, stalled result slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag and count disagree");

  // a full rejection is only reported with the queue at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == CNT_W'(DEPTH)))
    else $error("full status with room left");

endmodule
